FILE: rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksummed frame receiver: item kinds,
// event codes, register indexes, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // frame body header: checksum, command, length
  localparam int unsigned HDR_BYTES  = 3;
  // most payload bytes reported for one frame
  localparam int unsigned RESULT_CAP = 32;
  // width of the byte index field
  localparam int unsigned BIDX_W     = 5;

  // register reset values
  localparam logic [7:0]  RST_PREAMBLE  = 8'd254;
  localparam logic [7:0]  RST_POSTAMBLE = 8'd253;
  localparam logic [7:0]  RST_ACK       = 8'd250;
  localparam logic [7:0]  RST_NACK      = 8'd251;
  localparam logic [15:0] RST_IDLE_LIM  = 16'd100;

  // input item kind
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // result event codes
  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_ACK      = 2'd1,
    EV_NACK     = 2'd2,
    EV_CSUM_ERR = 2'd3
  } event_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PREAMBLE  = 3'd0,
    REG_POSTAMBLE = 3'd1,
    REG_ACK_CMD   = 3'd2,
    REG_NACK_CMD  = 3'd3,
    REG_IDLE_LIM  = 3'd4
  } cfg_reg_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_LOAD = 2'd2
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic take;   // input transaction completes this cycle
    logic rd;     // issue payload buffer read
    logic load;   // load the output register
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic end_hit;  // current input byte closes a frame
    logic burst;    // that frame is a data frame with payload
    logic more;     // payload bytes remain after the one being loaded
    logic out_free; // output register can take a new result
  } dp_stat_t;

endpackage

FILE: rtl/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cfr_ctrl.sv
// ----------------------------------------------------------------------------
// cfr_ctrl
// Controller of the frame receiver: takes input items one at a time and
// sequences the result burst at frame end (buffer read, output load).
// ----------------------------------------------------------------------------
module cfr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cfr_pkg::dp_stat_t stat_i,
  output cfr_pkg::dp_cmd_t  cmd_o
);
  import cfr_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (stat_i.end_hit) begin
            state_d = stat_i.burst ? ST_READ : ST_LOAD;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.more ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/cfr_dp.sv
// ----------------------------------------------------------------------------
// cfr_dp
// Datapath of the frame receiver: configuration registers, frame parser
// state, running checksum, payload buffer and the output register.
// ----------------------------------------------------------------------------
module cfr_dp #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_valid_i,
  input  logic [2:0]                  cfg_addr_i,
  input  logic [15:0]                 cfg_data_i,
  // input item fields
  input  logic                        op_i,
  input  logic [7:0]                  rx_byte_i,
  // controller link
  input  cfr_pkg::dp_cmd_t            cmd_i,
  output cfr_pkg::dp_stat_t           stat_o,
  // result
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output cfr_pkg::event_e             event_res_o,
  output logic [7:0]                  command_o,
  output logic [7:0]                  frame_length_o,
  output logic [7:0]                  data_byte_o,
  output logic [cfr_pkg::BIDX_W-1:0]  byte_index_o,
  output logic                        byte_valid_o,
  output logic                        last_o
);
  import cfr_pkg::*;

  localparam int unsigned CAP   = (MAX_PAYLOAD < RESULT_CAP) ? MAX_PAYLOAD : RESULT_CAP;
  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + HDR_BYTES + 1);
  localparam int unsigned CW    = $clog2(CAP + 1);
  localparam int unsigned AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // configuration registers
  logic [7:0]  pre_q, post_q, ack_q, nack_q;
  logic [15:0] lim_q;

  // parser state
  logic             in_frame_q, in_frame_d;
  logic [7:0]       prev_q, prev_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       chk_q, chk_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      idle_q, idle_d;
  logic             pend_q, pend_d;

  // result burst state
  event_e           ev_q, ev_d;
  logic             burst_q, burst_d;
  logic [CW-1:0]    elen_q, elen_d;
  logic [CW-1:0]    idx_q, idx_d;

  // output register
  logic              ovalid_q;
  event_e            oev_q;
  logic [7:0]        ocmd_q, olen_q, odata_q;
  logic [BIDX_W-1:0] oidx_q;
  logic              obv_q, olast_q;

  // combinational helpers
  logic             is_byte;
  logic             end_hit;
  logic [15:0]      idle_inc;
  logic             timeout;
  event_e           ev_n;
  logic             burst_n;
  logic [CW-1:0]    elen_n;
  logic             more;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_rdata;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= RST_PREAMBLE;
      post_q <= RST_POSTAMBLE;
      ack_q  <= RST_ACK;
      nack_q <= RST_NACK;
      lim_q  <= RST_IDLE_LIM;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_PREAMBLE:  pre_q  <= cfg_data_i[7:0];
        REG_POSTAMBLE: post_q <= cfg_data_i[7:0];
        REG_ACK_CMD:   ack_q  <= cfg_data_i[7:0];
        REG_NACK_CMD:  nack_q <= cfg_data_i[7:0];
        REG_IDLE_LIM:  lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame end detection and classification
  always_comb begin
    is_byte = (op_e'(op_i) == OP_BYTE);
    end_hit = is_byte && in_frame_q && (rx_byte_i == post_q) &&
              (cnt_q >= CNT_W'(HDR_BYTES)) &&
              (len_q == 8'(cnt_q - CNT_W'(HDR_BYTES)));
    if (sum_q != chk_q) begin
      ev_n = EV_CSUM_ERR;
    end else if (cmd_q == ack_q) begin
      ev_n = EV_ACK;
    end else if (cmd_q == nack_q) begin
      ev_n = EV_NACK;
    end else begin
      ev_n = EV_DATA;
    end
    burst_n = (ev_n == EV_DATA) && (len_q != 8'd0);
    elen_n  = (len_q > 8'(CAP)) ? CW'(CAP) : CW'(len_q);
    more    = burst_q && (CW'(idx_q + CW'(1)) != elen_q);
  end

  // saturating idle count and timeout
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign timeout  = pend_q && (idle_inc > lim_q);

  // payload buffer write
  assign ram_we    = cmd_i.take && is_byte && in_frame_q && !end_hit &&
                     (cnt_q < CNT_W'(MAX_PAYLOAD + HDR_BYTES)) &&
                     (cnt_q >= CNT_W'(HDR_BYTES));
  assign ram_waddr = AW'(cnt_q - CNT_W'(HDR_BYTES));

  // parser next state
  always_comb begin
    in_frame_d = in_frame_q;
    prev_d     = prev_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    idle_d     = idle_q;
    pend_d     = pend_q;
    ev_d       = ev_q;
    burst_d    = burst_q;
    elen_d     = elen_q;
    idx_d      = idx_q;
    if (cmd_i.take) begin
      if (!is_byte) begin
        // idle tick
        idle_d = idle_inc;
        if (timeout) begin
          in_frame_d = 1'b0;
          cnt_d      = '0;
          sum_d      = '0;
          prev_d     = '0;
          pend_d     = 1'b0;
          idle_d     = '0;
        end
      end else begin
        idle_d = '0;
        pend_d = 1'b1;
        if (in_frame_q) begin
          if (end_hit) begin
            // frame complete, latch the result burst
            prev_d     = rx_byte_i;
            in_frame_d = 1'b0;
            cnt_d      = '0;
            sum_d      = '0;
            pend_d     = 1'b0;
            ev_d       = ev_n;
            burst_d    = burst_n;
            elen_d     = elen_n;
            idx_d      = '0;
          end else if (cnt_q < CNT_W'(MAX_PAYLOAD + HDR_BYTES)) begin
            // body byte
            if (cnt_q == CNT_W'(0)) begin
              chk_d = rx_byte_i;
            end else begin
              if (cnt_q == CNT_W'(1)) begin
                cmd_d = rx_byte_i;
              end else if (cnt_q == CNT_W'(2)) begin
                len_d = rx_byte_i;
              end
              sum_d = sum_q + rx_byte_i;
            end
            cnt_d  = cnt_q + CNT_W'(1);
            prev_d = rx_byte_i;
          end else begin
            // overlong frame restarts the body
            cnt_d  = '0;
            sum_d  = '0;
            prev_d = '0;
          end
        end else begin
          // preamble hunt
          if ((prev_q == pre_q) && (rx_byte_i == pre_q)) begin
            in_frame_d = 1'b1;
            cnt_d      = '0;
            sum_d      = '0;
          end
          prev_d = rx_byte_i;
        end
      end
    end else if (cmd_i.load && burst_q) begin
      idx_d = idx_q + CW'(1);
    end
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      prev_q     <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
      chk_q      <= '0;
      cmd_q      <= '0;
      len_q      <= '0;
      idle_q     <= '0;
      pend_q     <= 1'b0;
      ev_q       <= EV_DATA;
      burst_q    <= 1'b0;
      elen_q     <= '0;
      idx_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      prev_q     <= prev_d;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      chk_q      <= chk_d;
      cmd_q      <= cmd_d;
      len_q      <= len_d;
      idle_q     <= idle_d;
      pend_q     <= pend_d;
      ev_q       <= ev_d;
      burst_q    <= burst_d;
      elen_q     <= elen_d;
      idx_q      <= idx_d;
    end
  end

  // payload buffer
  cfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd),
    .raddr_i (AW'(idx_q)),
    .rdata_o (ram_rdata)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      oev_q   <= ev_q;
      ocmd_q  <= cmd_q;
      olen_q  <= len_q;
      odata_q <= burst_q ? ram_rdata : 8'd0;
      oidx_q  <= burst_q ? BIDX_W'(idx_q) : '0;
      obv_q   <= burst_q;
      olast_q <= !more;
    end
  end

  assign stat_o.end_hit  = end_hit;
  assign stat_o.burst    = burst_n;
  assign stat_o.more     = more;
  assign stat_o.out_free = !ovalid_q || out_ready_i;

  assign out_valid_o    = ovalid_q;
  assign event_res_o    = oev_q;
  assign command_o      = ocmd_q;
  assign frame_length_o = olen_q;
  assign data_byte_o    = odata_q;
  assign byte_index_o   = oidx_q;
  assign byte_valid_o   = obv_q;
  assign last_o         = olast_q;

endmodule

FILE: rtl/checksummed_frame_receiver.sv
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Link frame receiver: preamble hunt, checksum check, ack/nack/data
// classification and byte-wise payload output.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser op, tdata rx_byte
//  m_axis    out        m_axis_tvalid / m_axis_tready  tuser event+flag, tdata
//  cfg       in         cfg_valid_i / cfg_ready_o      cfg_addr_i, cfg_data_i
//
// A byte or tick is taken whenever the receiver is idle. A frame-ending byte
// starts a result burst: a single output register load for a control, error
// or empty data result; for a data frame, a payload buffer read, then an
// output register load, for each reported payload byte, held by any output
// stall. Input is held off during the burst and taken again once the last
// result sits in the output register.
// No clearing pass after reset; the payload buffer is written before read.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] command, [15:8] frame_length,
                                      // [23:16] data_byte, [28:24] byte_index
  output logic [2:0]  m_axis_tuser,   // [1:0] event_res, [2] byte_valid
  output logic        m_axis_tlast,   // last
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);
  import cfr_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  event_e            event_res;
  logic [7:0]        command;
  logic [7:0]        frame_length;
  logic [7:0]        data_byte;
  logic [BIDX_W-1:0] byte_index;
  logic              byte_valid;

  // controller
  cfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  cfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (s_axis_tuser),
    .rx_byte_i      (s_axis_tdata),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .event_res_o    (event_res),
    .command_o      (command),
    .frame_length_o (frame_length),
    .data_byte_o    (data_byte),
    .byte_index_o   (byte_index),
    .byte_valid_o   (byte_valid),
    .last_o         (m_axis_tlast)
  );

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // result packing
  assign m_axis_tdata = {3'b000, byte_index, data_byte, frame_length, command};
  assign m_axis_tuser = {byte_valid, event_res};

endmodule

FILE: rtl/cfr_checker.sv
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module cfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import cfr_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a result without payload ends the burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tlast &&
      (m_axis_tdata[28:16] == 13'd0))
    else $error("event result carries payload or lacks last");

  // only data frames carry payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != EV_DATA) |-> !m_axis_tuser[2])
    else $error("control result flagged as payload");

  // idle ticks never start a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TICK)
      |=> !$rose(m_axis_tvalid))
    else $error("result after idle tick");

endmodule

bind checksummed_frame_receiver cfr_checker u_cfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
